/* rtl/rodc_pkg.sv */
// ----------------------------------------------------------------------------
// rodc_pkg
// Shared types, register codes and wrap-safe time helpers for the relay
// output dwell controller.
// ----------------------------------------------------------------------------
package rodc_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned AddrWidth = 4;

  typedef logic [TimeWidth-1:0] ms_t;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_PULSE = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DEFERRED = 2'd1,
    ST_REJECTED = 2'd2,
    ST_FAULTED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_MIN_ON   = 2'd0,
    REG_MIN_OFF  = 2'd1,
    REG_MAX_ON   = 2'd2,
    REG_POLARITY = 2'd3
  } reg_idx_t;

  typedef struct packed {
    ms_t  min_on;
    ms_t  min_off;
    ms_t  max_on;
    logic pol_high;
  } cfg_t;

  typedef struct packed {
    logic is_on;
    logic fault;
    logic pending_flag;
    logic pending_level;
    logic pulse_active;
    ms_t  last_change;
    ms_t  pulse_end;
  } ctl_state_t;

  typedef struct packed {
    opcode_t opcode;
    logic    want_on;
    ms_t     pulse_width;
    ms_t     now_time;
  } cmd_t;

  // Post-update view of one item, handed to the deadline stage.
  typedef struct packed {
    status_t status;
    logic    is_on;
    logic    fault;
    logic    pulse_active;
    logic    pending_flag;
    logic    wd_armed;
    ms_t     now_time;
    ms_t     pulse_end;
    ms_t     wd_target;
    ms_t     dwell_target;
  } snap_t;

  typedef struct packed {
    status_t status;
    logic    output_on;
    logic    pin_level;
    logic    fault_latched;
    logic    deadline_valid;
    ms_t     deadline_delay;
  } rsp_t;

  // True once now has reached when, modulo 2^32.
  function automatic logic has_reached(ms_t now, ms_t when);
    ms_t diff;
    diff = now - when;
    return ~diff[TimeWidth-1];
  endfunction

  function automatic ms_t time_left(ms_t now, ms_t when);
    ms_t left;
    left = when - now;
    return has_reached(now, when) ? '0 : left;
  endfunction

endpackage

/* rtl/rodc_cmd_if.sv */
// ----------------------------------------------------------------------------
// rodc_cmd_if
// Command channel: opcode, requested level, pulse width and timestamp.
// ----------------------------------------------------------------------------
interface rodc_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        want_on;
  logic [31:0] pulse_width;
  logic [31:0] now_time;

  modport source (output valid, opcode, want_on, pulse_width, now_time, input ready);
  modport sink (input valid, opcode, want_on, pulse_width, now_time, output ready);
endinterface

/* rtl/rodc_rsp_if.sv */
// ----------------------------------------------------------------------------
// rodc_rsp_if
// Result channel: status, output state, pin level, fault and next deadline.
// ----------------------------------------------------------------------------
interface rodc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        output_on;
  logic        pin_level;
  logic        fault_latched;
  logic        deadline_valid;
  logic [31:0] deadline_delay;

  modport source (output valid, status, output_on, pin_level, fault_latched,
                  deadline_valid, deadline_delay, input ready);
  modport sink (input valid, status, output_on, pin_level, fault_latched,
                deadline_valid, deadline_delay, output ready);
endinterface

/* rtl/relay_output_dwell_controller_core.sv */
// ----------------------------------------------------------------------------
// relay_output_dwell_controller_core
// Single relay output with on/off dwell enforcement, pulse validation and a
// max-on watchdog.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : command beats (opcode, want_on, pulse_width, now_time). A beat
//          moves when valid and ready are both high.
//   rsp  : one result beat per command, in command order.
//   APB  : min_on_time at 0x0, min_off_time at 0x4, max_on_time at 0x8,
//          pin polarity at 0xC. Write only while no command is in flight.
// Timing:
//   Three register stages: command register, state update, result register.
//   rsp.valid rises once the beat has passed the command, snapshot and result
//   registers, and one command is taken every cycle while rsp keeps up. The
//   state update commits as a command leaves the command register, so the
//   next command sees the state left by this one.
// Reset:
//   rst (synchronous, high) empties the pipe, returns the controller to off,
//   unfaulted, nothing pending, last change at time zero, and loads the
//   register defaults (all zero, pin polarity high when on).
// Stall:
//   While rsp.ready is low the result register holds its beat; the stages
//   behind it keep filling, and cmd.ready drops only once all are full.
// ----------------------------------------------------------------------------
module relay_output_dwell_controller_core (
  input  logic                              clk,
  input  logic                              rst,
  rodc_cmd_if.sink                          cmd,
  rodc_rsp_if.source                        rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rodc_pkg::AddrWidth-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Configuration registers.
  rodc_pkg::cfg_t       cfg;
  rodc_pkg::reg_idx_t   reg_idx;
  logic                 cfg_wr;

  // Controller state and its update.
  rodc_pkg::ctl_state_t state;
  rodc_pkg::ctl_state_t state_next;

  // Pipeline stages.
  logic                 s1_valid;
  rodc_pkg::cmd_t       s1_cmd;
  logic                 s2_valid;
  rodc_pkg::snap_t      s2_snap;
  rodc_pkg::snap_t      snap_next;
  logic                 o_valid;
  rodc_pkg::rsp_t       o_rsp;
  rodc_pkg::rsp_t       rsp_next;

  logic                 o_free;
  logic                 s2_free;
  logic                 s1_free;

  // ---------------------------------------------------------------------
  // APB register file
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = rodc_pkg::reg_idx_t'(paddr[rodc_pkg::AddrWidth-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_on   <= '0;
      cfg.min_off  <= '0;
      cfg.max_on   <= '0;
      cfg.pol_high <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rodc_pkg::REG_MIN_ON:   cfg.min_on   <= pwdata;
        rodc_pkg::REG_MIN_OFF:  cfg.min_off  <= pwdata;
        rodc_pkg::REG_MAX_ON:   cfg.max_on   <= pwdata;
        rodc_pkg::REG_POLARITY: cfg.pol_high <= pwdata[0];
        default:                cfg.pol_high <= cfg.pol_high;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rodc_pkg::REG_MIN_ON:   prdata = cfg.min_on;
      rodc_pkg::REG_MIN_OFF:  prdata = cfg.min_off;
      rodc_pkg::REG_MAX_ON:   prdata = cfg.max_on;
      rodc_pkg::REG_POLARITY: prdata = {31'd0, cfg.pol_high};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Flow control: each stage advances when the one ahead is empty or
  // draining this cycle.
  // ---------------------------------------------------------------------
  assign o_free    = !o_valid || rsp.ready;
  assign s2_free   = !s2_valid || o_free;
  assign s1_free   = !s1_valid || s2_free;
  assign cmd.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= cmd.valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (o_free) begin
        o_valid <= s2_valid;
      end
    end
  end

  // Payload registers: load only when a beat moves in.
  always_ff @(posedge clk) begin
    if (s1_free && cmd.valid) begin
      s1_cmd.opcode      <= rodc_pkg::opcode_t'(cmd.opcode);
      s1_cmd.want_on     <= cmd.want_on;
      s1_cmd.pulse_width <= cmd.pulse_width;
      s1_cmd.now_time    <= cmd.now_time;
    end
    if (s2_free && s1_valid) begin
      s2_snap <= snap_next;
    end
    if (o_free && s2_valid) begin
      o_rsp <= rsp_next;
    end
  end

  // ---------------------------------------------------------------------
  // Controller state: commit the update as the command leaves stage one.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state.is_on         <= 1'b0;
      state.fault         <= 1'b0;
      state.pending_flag  <= 1'b0;
      state.pending_level <= 1'b0;
      state.pulse_active  <= 1'b0;
      state.last_change   <= '0;
      state.pulse_end     <= '0;
    end else if (s1_valid && s2_free) begin
      state <= state_next;
    end
  end

  rodc_update u_update (
    .cfg        (cfg),
    .state      (state),
    .cmd        (s1_cmd),
    .state_next (state_next),
    .snap       (snap_next)
  );

  // Earliest deadline and pin polarity for the result beat.
  rodc_deadline u_deadline (
    .snap     (s2_snap),
    .pol_high (cfg.pol_high),
    .rsp      (rsp_next)
  );

  // ---------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------
  assign rsp.valid          = o_valid;
  assign rsp.status         = o_rsp.status;
  assign rsp.output_on      = o_rsp.output_on;
  assign rsp.pin_level      = o_rsp.pin_level;
  assign rsp.fault_latched  = o_rsp.fault_latched;
  assign rsp.deadline_valid = o_rsp.deadline_valid;
  assign rsp.deadline_delay = o_rsp.deadline_delay;

endmodule

/* rtl/rodc_update.sv */
// ----------------------------------------------------------------------------
// rodc_update
// Applies one command to the controller state and forms the status and the
// deadline targets seen after the command.
// ----------------------------------------------------------------------------
module rodc_update (
  input  rodc_pkg::cfg_t       cfg,
  input  rodc_pkg::ctl_state_t state,
  input  rodc_pkg::cmd_t       cmd,
  output rodc_pkg::ctl_state_t state_next,
  output rodc_pkg::snap_t      snap
);

  rodc_pkg::ms_t   elapsed;
  rodc_pkg::ms_t   need;
  rodc_pkg::ms_t   need_next;
  logic            dwell_met;
  logic            wd_hit;
  logic            pulse_done;
  logic            width_bad;
  rodc_pkg::status_t status;

  assign elapsed  = cmd.now_time - state.last_change;
  assign need     = state.is_on ? cfg.min_on : cfg.min_off;
  assign dwell_met = (elapsed >= need);
  assign wd_hit   = state.is_on && (cfg.max_on != '0) && (elapsed >= cfg.max_on);
  assign pulse_done = state.pulse_active && state.is_on &&
                      rodc_pkg::has_reached(cmd.now_time, state.pulse_end);
  assign width_bad = (cmd.pulse_width == '0) || (cmd.pulse_width < cfg.min_on) ||
                     ((cfg.max_on != '0) && (cmd.pulse_width > cfg.max_on)) ||
                     (!state.is_on && !dwell_met);

  always_comb begin
    state_next = state;
    status     = rodc_pkg::ST_OK;
    unique case (cmd.opcode)
      rodc_pkg::OP_SET: begin
        if (state.fault) begin
          status = rodc_pkg::ST_FAULTED;
        end else begin
          state_next.pulse_active = 1'b0;
          if (cmd.want_on == state.is_on) begin
            state_next.pending_flag = 1'b0;
          end else if (dwell_met) begin
            state_next.pending_flag = 1'b0;
            state_next.is_on        = cmd.want_on;
            state_next.last_change  = cmd.now_time;
          end else begin
            state_next.pending_flag  = 1'b1;
            state_next.pending_level = cmd.want_on;
            status                   = rodc_pkg::ST_DEFERRED;
          end
        end
      end
      rodc_pkg::OP_PULSE: begin
        if (state.fault) begin
          status = rodc_pkg::ST_FAULTED;
        end else if (width_bad) begin
          status = rodc_pkg::ST_REJECTED;
        end else begin
          state_next.pending_flag = 1'b0;
          if (!state.is_on) begin
            state_next.is_on       = 1'b1;
            state_next.last_change = cmd.now_time;
          end
          state_next.pulse_active = 1'b1;
          state_next.pulse_end    = cmd.now_time + cmd.pulse_width;
        end
      end
      rodc_pkg::OP_TICK: begin
        priority if (state.fault) begin
          // Hold the output off while faulted.
          if (state.is_on) begin
            state_next.is_on       = 1'b0;
            state_next.last_change = cmd.now_time;
          end
          state_next.pulse_active = 1'b0;
          status                  = rodc_pkg::ST_FAULTED;
        end else if (wd_hit) begin
          state_next.is_on        = 1'b0;
          state_next.last_change  = cmd.now_time;
          state_next.pulse_active = 1'b0;
          state_next.pending_flag = 1'b0;
          state_next.fault        = 1'b1;
          status                  = rodc_pkg::ST_FAULTED;
        end else if (pulse_done) begin
          state_next.is_on        = 1'b0;
          state_next.last_change  = cmd.now_time;
          state_next.pulse_active = 1'b0;
        end else if (state.pending_flag && dwell_met) begin
          state_next.pending_flag = 1'b0;
          if (state.pending_level != state.is_on) begin
            state_next.is_on       = state.pending_level;
            state_next.last_change = cmd.now_time;
          end
          if (!state.pending_level) begin
            state_next.pulse_active = 1'b0;
          end
        end else begin
          state_next.fault = state.fault;
        end
      end
      rodc_pkg::OP_CLEAR: begin
        state_next.fault        = 1'b0;
        state_next.pending_flag = 1'b0;
        state_next.pulse_active = 1'b0;
        state_next.is_on        = 1'b0;
        state_next.last_change  = cmd.now_time;
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  assign need_next = state_next.is_on ? cfg.min_on : cfg.min_off;

  always_comb begin
    snap.status       = status;
    snap.is_on        = state_next.is_on;
    snap.fault        = state_next.fault;
    snap.pulse_active = state_next.pulse_active;
    snap.pending_flag = state_next.pending_flag;
    snap.wd_armed     = state_next.is_on && (cfg.max_on != '0);
    snap.now_time     = cmd.now_time;
    snap.pulse_end    = state_next.pulse_end;
    snap.wd_target    = state_next.last_change + cfg.max_on;
    snap.dwell_target = state_next.last_change + need_next;
  end

endmodule

/* rtl/rodc_deadline.sv */
// ----------------------------------------------------------------------------
// rodc_deadline
// Picks the earliest live deadline and forms the result beat.
// ----------------------------------------------------------------------------
module rodc_deadline (
  input  rodc_pkg::snap_t snap,
  input  logic            pol_high,
  output rodc_pkg::rsp_t  rsp
);

  rodc_pkg::ms_t t_wd;
  rodc_pkg::ms_t t_pulse;
  rodc_pkg::ms_t t_dwell;
  logic          en_wd;
  logic          en_pulse;
  logic          en_dwell;
  rodc_pkg::ms_t best;
  logic          found;

  assign t_wd    = rodc_pkg::time_left(snap.now_time, snap.wd_target);
  assign t_pulse = rodc_pkg::time_left(snap.now_time, snap.pulse_end);
  assign t_dwell = rodc_pkg::time_left(snap.now_time, snap.dwell_target);

  assign en_wd    = !snap.fault && snap.wd_armed;
  assign en_pulse = !snap.fault && snap.pulse_active && snap.is_on;
  assign en_dwell = !snap.fault && snap.pending_flag;

  always_comb begin
    best  = '0;
    found = 1'b0;
    if (en_wd) begin
      best  = t_wd;
      found = 1'b1;
    end
    if (en_pulse && (!found || (t_pulse < best))) begin
      best  = t_pulse;
      found = 1'b1;
    end
    if (en_dwell && (!found || (t_dwell < best))) begin
      best  = t_dwell;
      found = 1'b1;
    end
  end

  always_comb begin
    rsp.status         = snap.status;
    rsp.output_on      = snap.is_on;
    rsp.pin_level      = pol_high ? snap.is_on : ~snap.is_on;
    rsp.fault_latched  = snap.fault;
    rsp.deadline_valid = found;
    rsp.deadline_delay = best;
  end

endmodule

/* rtl/rodc_checker.sv */
// ----------------------------------------------------------------------------
// rodc_checker
// Port-level checks for the relay output dwell controller, bound to the top.
// ----------------------------------------------------------------------------
module rodc_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic        rsp_output_on,
  input logic        rsp_pin_level,
  input logic        rsp_fault_latched,
  input logic        rsp_deadline_valid,
  input logic [31:0] rsp_deadline_delay
);

  // A stalled result beat holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_output_on) && $stable(rsp_pin_level) &&
      $stable(rsp_fault_latched) && $stable(rsp_deadline_valid) &&
      $stable(rsp_deadline_delay))
    else $error("result beat changed while stalled");

  a_no_deadline_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_deadline_valid |-> rsp_deadline_delay == 32'd0)
    else $error("deadline delay nonzero without a deadline");

  // The watchdog drops the output, and nothing can drive it on while faulted.
  a_fault_off: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_fault_latched |-> !rsp_output_on && !rsp_deadline_valid)
    else $error("output on or deadline live while faulted");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && cmd_ready)
    else $error("pipe not empty after reset");

endmodule

bind relay_output_dwell_controller_core rodc_checker u_rodc_checker (
  .clk                (clk),
  .rst                (rst),
  .cmd_ready          (cmd.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_output_on      (rsp.output_on),
  .rsp_pin_level      (rsp.pin_level),
  .rsp_fault_latched  (rsp.fault_latched),
  .rsp_deadline_valid (rsp.deadline_valid),
  .rsp_deadline_delay (rsp.deadline_delay)
);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the relay output dwell controller. A queue-fed
// driver sends command beats with random idle gaps, and a monitor checks every
// result beat against a model of the dwell, pulse and watchdog rules kept in
// the bench. Register settings change over APB between drained phases.
// ----------------------------------------------------------------------------
module testbench;
  import rodc_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  rodc_cmd_if cmd_ch();
  rodc_rsp_if rsp_ch();

  relay_output_dwell_controller_core dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register copies, updated on the APB write edge. Writes only happen while
  // the pipe is empty, so the model sees them in the same order as the DUT.
  ms_t  cfg_min_on;
  ms_t  cfg_min_off;
  ms_t  cfg_max_on;
  logic cfg_pol_high;

  // Controller state as the model tracks it.
  logic s_on;
  logic s_fault;
  logic s_pend;
  logic s_pend_lvl;
  logic s_pulse;
  ms_t  s_last;
  ms_t  s_pulse_end;

  cmd_t        cmds_waiting[$];      // command beats not yet offered
  rsp_t        relay_results_due[$]; // predicted result beats, oldest first
  cmd_t        on_offer;             // beat currently driven on cmd_ch
  logic        beat_taken;
  logic        steady;               // no idling on either side when set
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned n_queued;
  int unsigned n_checked;
  int unsigned n_errors;

  // --------------------------------------------------------------------------
  // Time arithmetic, all modulo 2^32
  // --------------------------------------------------------------------------
  function automatic logic span_done(ms_t now, ms_t since, ms_t span);
    ms_t d;
    d = now - since;
    return d >= span;
  endfunction

  // Deadline reached when now - when is non-negative as a signed value.
  function automatic logic reached(ms_t now, ms_t when);
    ms_t d;
    d = now - when;
    return !d[TimeWidth-1];
  endfunction

  function automatic ms_t ms_until(ms_t now, ms_t when);
    return reached(now, when) ? '0 : ms_t'(when - now);
  endfunction

  // Dwell of the current level, min_on while on and min_off while off.
  function automatic logic dwell_over(ms_t now);
    ms_t need;
    need = s_on ? cfg_min_on : cfg_min_off;
    return need == '0 || span_done(now, s_last, need);
  endfunction

  function automatic void switch_to(logic lvl, ms_t now);
    if (s_on != lvl) begin
      s_on   = lvl;
      s_last = now;
    end
    if (!lvl) s_pulse = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Apply one command to the model state and return the result beat it owes
  // --------------------------------------------------------------------------
  function automatic rsp_t relay_step(cmd_t c);
    status_t st;
    logic    found;
    ms_t     best;
    ms_t     t;
    ms_t     need;
    ms_t     now;
    rsp_t    r;
    now = c.now_time;
    st  = ST_OK;
    case (c.opcode)
      OP_SET: begin
        if (s_fault) begin
          st = ST_FAULTED;
        end else begin
          s_pulse = 1'b0;
          if (c.want_on == s_on) begin
            s_pend = 1'b0;
          end else if (dwell_over(now)) begin
            s_pend = 1'b0;
            switch_to(c.want_on, now);
          end else begin
            // Too early: park the request for a later tick.
            s_pend     = 1'b1;
            s_pend_lvl = c.want_on;
            st         = ST_DEFERRED;
          end
        end
      end
      OP_PULSE: begin
        if (s_fault) begin
          st = ST_FAULTED;
        end else if (c.pulse_width == '0 || c.pulse_width < cfg_min_on ||
                     (cfg_max_on != '0 && c.pulse_width > cfg_max_on) ||
                     (!s_on && !dwell_over(now))) begin
          st = ST_REJECTED;
        end else begin
          s_pend = 1'b0;
          switch_to(1'b1, now);
          s_pulse     = 1'b1;
          s_pulse_end = now + c.pulse_width;
        end
      end
      OP_TICK: begin
        if (s_fault) begin
          switch_to(1'b0, now);
          st = ST_FAULTED;
        end else if (s_on && cfg_max_on != '0 && span_done(now, s_last, cfg_max_on)) begin
          // Watchdog trips: force off and latch the fault.
          switch_to(1'b0, now);
          s_pulse = 1'b0;
          s_pend  = 1'b0;
          s_fault = 1'b1;
          st      = ST_FAULTED;
        end else if (s_pulse && s_on && reached(now, s_pulse_end)) begin
          switch_to(1'b0, now);
        end else if (s_pend && dwell_over(now)) begin
          s_pend = 1'b0;
          switch_to(s_pend_lvl, now);
        end
      end
      default: begin
        s_fault = 1'b0;
        s_pend  = 1'b0;
        s_pulse = 1'b0;
        s_on    = 1'b0;
        s_last  = now;
      end
    endcase

    // Report the earliest of watchdog expiry, pulse end and pending dwell end.
    found = 1'b0;
    best  = '0;
    if (!s_fault) begin
      if (s_on && cfg_max_on != '0) begin
        best  = ms_until(now, s_last + cfg_max_on);
        found = 1'b1;
      end
      if (s_pulse && s_on) begin
        t = ms_until(now, s_pulse_end);
        if (!found || t < best) begin
          best  = t;
          found = 1'b1;
        end
      end
      if (s_pend) begin
        need = s_on ? cfg_min_on : cfg_min_off;
        t    = ms_until(now, s_last + need);
        if (!found || t < best) begin
          best  = t;
          found = 1'b1;
        end
      end
    end

    r.status         = st;
    r.output_on      = s_on;
    r.pin_level      = cfg_pol_high ? s_on : !s_on;
    r.fault_latched  = s_fault;
    r.deadline_valid = found;
    r.deadline_delay = found ? best : '0;
    return r;
  endfunction

  function automatic void check_field(string label, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, want_v, got_v);
      n_errors++;
    end
  endfunction

  // Mostly no gap, otherwise usually a short gap and now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic queue_cmd(opcode_t op, logic want, ms_t width, ms_t at);
    cmd_t c;
    c.opcode      = op;
    c.want_on     = want;
    c.pulse_width = width;
    c.now_time    = at;
    cmds_waiting.push_back(c);
    n_queued++;
  endtask

  // Hold until every queued command has come back as a checked result.
  task automatic wait_drained();
    while (n_checked != n_queued) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MIN_ON:  cfg_min_on   = val;
      REG_MIN_OFF: cfg_min_off  = val;
      REG_MAX_ON:  cfg_max_on   = val;
      default:     cfg_pol_high = val[0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("relay_output_dwell_controller_core verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Command driver: offer queued beats at the falling edge, hold a beat until
  // it is taken, and insert random idle gaps between beats
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (cmd_ch.valid && !beat_taken) begin
      // hold the current beat
    end else begin
      beat_taken = 1'b0;
      if (send_gap != 0 || cmds_waiting.size() == 0) begin
        if (send_gap != 0) send_gap--;
        cmd_ch.valid <= 1'b0;
      end else begin
        on_offer = cmds_waiting.pop_front();
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= on_offer.opcode;
        cmd_ch.want_on     <= on_offer.want_on;
        cmd_ch.pulse_width <= on_offer.pulse_width;
        cmd_ch.now_time    <= on_offer.now_time;
        send_gap = idle_len();
      end
    end
  end

  // Predict at the edge the beat moves, so the model sees commands in the
  // order the DUT takes them.
  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      relay_results_due.push_back(relay_step(on_offer));
      beat_taken = 1'b1;
    end
  end

  // Result sink: stall at random, with runs of no stalls in steady phases.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len();
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Result monitor: compare each result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (relay_results_due.size() == 0) begin
        $display("%0t: result beat with nothing expected, got status %0d", $time,
                 rsp_ch.status);
        n_errors++;
      end else begin
        want = relay_results_due.pop_front();
        n_checked++;
        check_field("status", 32'(want.status), 32'(rsp_ch.status));
        check_field("output_on", 32'(want.output_on), 32'(rsp_ch.output_on));
        check_field("pin_level", 32'(want.pin_level), 32'(rsp_ch.pin_level));
        check_field("fault_latched", 32'(want.fault_latched),
                    32'(rsp_ch.fault_latched));
        check_field("deadline_valid", 32'(want.deadline_valid),
                    32'(rsp_ch.deadline_valid));
        check_field("deadline_delay", want.deadline_delay, rsp_ch.deadline_delay);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed checks, then random phases under changing settings
  // --------------------------------------------------------------------------
  initial begin : stimulus
    ms_t         wall;
    ms_t         width;
    ms_t         b;
    ms_t         mn;
    ms_t         mf;
    ms_t         mx;
    logic        ah;
    int unsigned pick;
    opcode_t     op;

    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.opcode      = OP_TICK;
    cmd_ch.want_on     = 1'b0;
    cmd_ch.pulse_width = '0;
    cmd_ch.now_time    = '0;
    rsp_ch.ready       = 1'b0;
    beat_taken = 1'b0;
    steady     = 1'b0;
    send_gap   = 0;
    stall_left = 0;
    n_queued   = 0;
    n_checked  = 0;
    n_errors   = 0;

    // Reset state: init at time zero, register defaults.
    cfg_min_on   = '0;
    cfg_min_off  = '0;
    cfg_max_on   = '0;
    cfg_pol_high = 1'b1;
    s_on        = 1'b0;
    s_fault     = 1'b0;
    s_pend      = 1'b0;
    s_pend_lvl  = 1'b0;
    s_pulse     = 1'b0;
    s_last      = '0;
    s_pulse_end = '0;

    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default registers: no dwell, no watchdog. Cover repeat set, zero and
    // full-range pulse widths (the full width wraps its end time) and clear.
    queue_cmd(OP_SET,   1'b1, '0, 32'd0);
    queue_cmd(OP_SET,   1'b1, '0, 32'd5);
    queue_cmd(OP_PULSE, 1'b0, '0, 32'd6);
    queue_cmd(OP_PULSE, 1'b0, '1, 32'd7);
    queue_cmd(OP_TICK,  1'b0, '0, 32'd8);
    queue_cmd(OP_SET,   1'b0, '0, 32'd9);
    queue_cmd(OP_CLEAR, 1'b1, '1, '1);
    wait_drained();

    // Tight dwell and watchdog, inverted pin, timestamps crossing the wrap.
    write_reg(REG_MIN_ON, 32'd20);
    write_reg(REG_MIN_OFF, 32'd10);
    write_reg(REG_MAX_ON, 32'd50);
    write_reg(REG_POLARITY, 32'd0);
    b = 32'hFFFF_FFF8;
    queue_cmd(OP_CLEAR, 1'b0, '0, b);
    queue_cmd(OP_SET,   1'b1, '0, b + 32'd3);     // off dwell open: deferred
    queue_cmd(OP_PULSE, 1'b0, 32'd30, b + 32'd4); // off dwell open: rejected
    queue_cmd(OP_TICK,  1'b0, '0, b + 32'd12);    // pending on applies
    queue_cmd(OP_SET,   1'b0, '0, b + 32'd20);    // on dwell open: deferred
    queue_cmd(OP_TICK,  1'b0, '0, b + 32'd40);    // pending off applies
    queue_cmd(OP_PULSE, 1'b0, 32'd10, b + 32'd60); // shorter than min on
    queue_cmd(OP_PULSE, 1'b0, 32'd60, b + 32'd61); // longer than max on
    queue_cmd(OP_PULSE, 1'b0, 32'd30, b + 32'd62);
    queue_cmd(OP_SET,   1'b1, '0, b + 32'd70);    // same level cancels pulse
    queue_cmd(OP_TICK,  1'b0, '0, b + 32'd120);   // watchdog trips
    queue_cmd(OP_SET,   1'b1, '0, b + 32'd121);
    queue_cmd(OP_PULSE, 1'b0, 32'd30, b + 32'd122);
    queue_cmd(OP_TICK,  1'b0, '0, b + 32'd123);
    queue_cmd(OP_CLEAR, 1'b0, '0, b + 32'd124);
    wait_drained();

    for (int p = 0; p < 11; p++) begin
      // Extremes first, then random dwell and watchdog settings.
      case (p)
        0: begin
          mn = '0; mf = '0; mx = '0; ah = 1'b1;
        end
        1: begin
          mn = '1; mf = '1; mx = '1; ah = 1'b0;
        end
        2: begin
          mn = '1; mf = '0; mx = '0; ah = 1'b1;
        end
        3: begin
          mn = '0; mf = '1; mx = 32'd1; ah = 1'b0;
        end
        default: begin
          mn = $urandom_range(0, 40);
          mf = $urandom_range(0, 40);
          mx = ($urandom_range(0, 3) == 0) ? '0 : ms_t'($urandom_range(20, 150));
          ah = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(REG_MIN_ON, mn);
      write_reg(REG_MIN_OFF, mf);
      write_reg(REG_MAX_ON, mx);
      write_reg(REG_POLARITY, {31'd0, ah});
      steady = (p % 4 == 2);
      // Start some phases just below the wrap point.
      wall = (p % 3 == 0) ? ms_t'(32'hFFFF_FF00 + $urandom_range(0, 200)) : ms_t'($urandom);

      for (int k = 0; k < 40; k++) begin
        // Advance time mostly in small steps so dwell and pulse deadlines get
        // hit; jump or step back now and then.
        pick = $urandom_range(0, 99);
        if (pick < 75) wall = wall + $urandom_range(0, 12);
        else if (pick < 92) wall = wall + $urandom_range(13, 200);
        else if (pick < 97) wall = $urandom;
        else wall = wall - $urandom_range(1, 20);

        pick = $urandom_range(0, 99);
        op = (pick < 40) ? OP_TICK : (pick < 70) ? OP_SET : (pick < 92) ? OP_PULSE : OP_CLEAR;

        // Aim pulse widths at the envelope edges as well as inside it.
        pick = $urandom_range(0, 99);
        if (pick < 55) width = $urandom_range(1, 80);
        else if (pick < 70) width = cfg_min_on;
        else if (pick < 80) width = cfg_max_on;
        else if (pick < 88) width = '0;
        else width = $urandom;

        queue_cmd(op, 1'($urandom_range(0, 1)), width, wall);
      end
      wait_drained();
    end
    steady = 1'b0;

    // Wait so that any stray result beat can still show up.
    repeat (8) @(negedge clk);
    if (n_errors == 0 && relay_results_due.size() == 0) begin
      $display("relay_output_dwell_controller_core verification clean");
    end else begin
      $display("relay_output_dwell_controller_core verification failed");
    end
    $finish;
  end

endmodule
